>>> sv/rwg_pkg.sv
// Types, constants and microcode store for the Reno window growth block.
`timescale 1ns / 1ps

package rwg_pkg;

	localparam int unsigned UPC_W = 4;
	localparam int unsigned ADDR_W = 3;
	localparam logic [15:0] SEGMENT_RESET = 16'd536;
	localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

	// Operation codes of an input beat
	localparam logic OP_ACK = 1'b0;
	localparam logic OP_LOSS = 1'b1;

	// Register index (bit 2 of the byte address)
	localparam logic REG_SEGMENT = 1'b0;

	typedef logic [UPC_W-1:0] upc_t;

	typedef struct packed {
		logic        operation;
		logic [31:0] window_bytes;
		logic [31:0] threshold_bytes;
		logic [15:0] acked_segments;
	} in_item_t;

	typedef struct packed {
		logic [31:0] proposed_window;
		logic [31:0] new_threshold;
		logic        slow_start_phase;
	} out_item_t;

	// Datapath operations
	typedef enum logic [3:0] {
		UOP_NOP,
		UOP_DIV_SEG,
		UOP_DIV_CNT,
		UOP_DIV_STEP,
		UOP_SET_W,
		UOP_CMP_RESET,
		UOP_ADD_ACK,
		UOP_TAKE_REM,
		UOP_ADD_PROD,
		UOP_FIN_CA,
		UOP_SS_MUL,
		UOP_FIN_SS,
		UOP_FIN_LOSS
	} uop_t;

	// Sequencing conditions
	typedef enum logic [2:0] {
		JC_NEXT,
		JC_LOSS,
		JC_SLOW,
		JC_LOOP,
		JC_BELOW
	} jc_t;

	typedef struct packed {
		uop_t uop;
		jc_t  jc;
		upc_t target;
		logic last;
	} ctl_t;

	// Step addresses
	localparam upc_t U_CHK_LOSS  = 4'd0;
	localparam upc_t U_CHK_SLOW  = 4'd1;
	localparam upc_t U_DIV_SEG   = 4'd2;
	localparam upc_t U_DIV_STEP1 = 4'd3;
	localparam upc_t U_SET_W     = 4'd4;
	localparam upc_t U_CMP1      = 4'd5;
	localparam upc_t U_ADD_ACK   = 4'd6;
	localparam upc_t U_CHK_GE    = 4'd7;
	localparam upc_t U_DIV_CNT   = 4'd8;
	localparam upc_t U_DIV_STEP2 = 4'd9;
	localparam upc_t U_TAKE_REM  = 4'd10;
	localparam upc_t U_ADD_PROD  = 4'd11;
	localparam upc_t U_FIN_CA    = 4'd12;
	localparam upc_t U_SS_MUL    = 4'd13;
	localparam upc_t U_FIN_SS    = 4'd14;
	localparam upc_t U_FIN_LOSS  = 4'd15;

	// Microcode store: one control word per step
	function automatic ctl_t ucode(input upc_t upc);
		ctl_t c;
		c = '{uop: UOP_NOP, jc: JC_NEXT, target: U_CHK_LOSS, last: 1'b0};
		unique case (upc)
			U_CHK_LOSS:  c = '{uop: UOP_NOP,       jc: JC_LOSS,  target: U_FIN_LOSS,  last: 1'b0};
			U_CHK_SLOW:  c = '{uop: UOP_NOP,       jc: JC_SLOW,  target: U_SS_MUL,    last: 1'b0};
			U_DIV_SEG:   c = '{uop: UOP_DIV_SEG,   jc: JC_NEXT,  target: U_CHK_LOSS,  last: 1'b0};
			U_DIV_STEP1: c = '{uop: UOP_DIV_STEP,  jc: JC_LOOP,  target: U_DIV_STEP1, last: 1'b0};
			U_SET_W:     c = '{uop: UOP_SET_W,     jc: JC_NEXT,  target: U_CHK_LOSS,  last: 1'b0};
			U_CMP1:      c = '{uop: UOP_CMP_RESET, jc: JC_NEXT,  target: U_CHK_LOSS,  last: 1'b0};
			U_ADD_ACK:   c = '{uop: UOP_ADD_ACK,   jc: JC_NEXT,  target: U_CHK_LOSS,  last: 1'b0};
			U_CHK_GE:    c = '{uop: UOP_NOP,       jc: JC_BELOW, target: U_FIN_CA,    last: 1'b0};
			U_DIV_CNT:   c = '{uop: UOP_DIV_CNT,   jc: JC_NEXT,  target: U_CHK_LOSS,  last: 1'b0};
			U_DIV_STEP2: c = '{uop: UOP_DIV_STEP,  jc: JC_LOOP,  target: U_DIV_STEP2, last: 1'b0};
			U_TAKE_REM:  c = '{uop: UOP_TAKE_REM,  jc: JC_NEXT,  target: U_CHK_LOSS,  last: 1'b0};
			U_ADD_PROD:  c = '{uop: UOP_ADD_PROD,  jc: JC_NEXT,  target: U_CHK_LOSS,  last: 1'b0};
			U_FIN_CA:    c = '{uop: UOP_FIN_CA,    jc: JC_NEXT,  target: U_CHK_LOSS,  last: 1'b1};
			U_SS_MUL:    c = '{uop: UOP_SS_MUL,    jc: JC_NEXT,  target: U_CHK_LOSS,  last: 1'b0};
			U_FIN_SS:    c = '{uop: UOP_FIN_SS,    jc: JC_NEXT,  target: U_CHK_LOSS,  last: 1'b1};
			U_FIN_LOSS:  c = '{uop: UOP_FIN_LOSS,  jc: JC_NEXT,  target: U_CHK_LOSS,  last: 1'b1};
			default:     c = '{uop: UOP_NOP,       jc: JC_NEXT,  target: U_CHK_LOSS,  last: 1'b1};
		endcase
		return c;
	endfunction

endpackage

>>> sv/reno_window_growth.sv
// Top level of the Reno window growth block: microcode sequencer and datapath.
`timescale 1ns / 1ps

// Proposes TCP Reno congestion window values, one result beat per input beat.
// A loss beat and a slow start ack need no division; a congestion avoidance ack
// runs one division, or two when the counted acks reach a full window and must be
// divided out. The pace is set by one shared restoring divider that retires one
// quotient bit per cycle, run by a 16-step microcode program. One item is in work
// at a time; the next input beat is taken as soon as the previous result sits in
// the output register, even if that result is still stalled. segment_bytes lies at
// byte address 0 and must be written by the user only while the block is idle (the
// block does not enforce this); a value of 0 is treated as 1.
module reno_window_growth (
	input  logic                      clk,
	input  logic                      arst_n,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  rwg_pkg::in_item_t         in_item,
	// output channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output rwg_pkg::out_item_t        out_item,
	// configuration
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [rwg_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	// Sequencer
	logic             busy_q;
	rwg_pkg::upc_t    upc_q;
	rwg_pkg::ctl_t    ctl;
	logic             fire;
	logic             jump;
	logic             in_accept;

	// Configuration and persistent state
	logic [15:0]      segment_q;
	logic [31:0]      cnt_q;

	// Working registers
	logic             op_q;
	logic [31:0]      win_q;
	logic [31:0]      thr_q;
	logic [15:0]      acked_q;
	logic [31:0]      w_q;
	logic [47:0]      prod_q;

	// Divider
	logic [31:0]      rem_q;
	logic [31:0]      quo_q;
	logic [31:0]      dvs_q;
	logic [4:0]       div_cnt_q;
	logic [32:0]      div_sh;
	logic [33:0]      div_diff;

	// Output register
	logic             out_valid_q;
	rwg_pkg::out_item_t out_q;

	// Combinational datapath
	logic [15:0]      seg;
	logic [31:0]      mul_a;
	logic [47:0]      mul_p;
	logic [48:0]      prod_sum;
	logic [31:0]      win_plus_prod;
	logic [32:0]      seg_sum;
	logic [31:0]      win_plus_seg;
	logic [32:0]      ack_sum;
	logic [31:0]      cnt_plus_ack;
	logic [16:0]      two_seg;
	logic [31:0]      half_win;

	assign in_accept = in_valid && !busy_q;
	assign in_stall  = busy_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign pready    = 1'b1;

	// Register read
	always_comb begin
		prdata = '0;
		if (paddr[2] == rwg_pkg::REG_SEGMENT) begin
			prdata = {16'd0, segment_q};
		end
	end

	// Register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_q <= rwg_pkg::SEGMENT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == rwg_pkg::REG_SEGMENT) begin
			segment_q <= pwdata[15:0];
		end
	end

	// Shared arithmetic
	always_comb begin
		seg           = (segment_q == 16'd0) ? 16'd1 : segment_q;
		mul_a         = (ctl.uop == rwg_pkg::UOP_SS_MUL) ? {16'd0, acked_q} : quo_q;
		mul_p         = {16'd0, mul_a} * {32'd0, seg};
		prod_sum      = {17'd0, win_q} + {1'b0, prod_q};
		win_plus_prod = (prod_sum > {17'd0, rwg_pkg::MAX32}) ? rwg_pkg::MAX32 : prod_sum[31:0];
		seg_sum       = {1'b0, win_q} + {17'd0, seg};
		win_plus_seg  = seg_sum[32] ? rwg_pkg::MAX32 : seg_sum[31:0];
		ack_sum       = {1'b0, cnt_q} + {17'd0, acked_q};
		cnt_plus_ack  = ack_sum[32] ? rwg_pkg::MAX32 : ack_sum[31:0];
		two_seg       = {seg, 1'b0};
		half_win      = {1'b0, win_q[31:1]};
		div_sh        = {rem_q, quo_q[31]};
		div_diff      = {1'b0, div_sh} - {2'd0, dvs_q};
	end

	// Decode the current step and hold a finishing step while the output is full
	always_comb begin
		ctl  = rwg_pkg::ucode(upc_q);
		fire = busy_q && !(ctl.last && out_valid_q && out_stall);
		case (ctl.jc)
			rwg_pkg::JC_LOSS:  jump = (op_q == rwg_pkg::OP_LOSS);
			rwg_pkg::JC_SLOW:  jump = (win_q < thr_q);
			rwg_pkg::JC_LOOP:  jump = (div_cnt_q != 5'd0);
			rwg_pkg::JC_BELOW: jump = (cnt_q < w_q);
			default:           jump = 1'b0;
		endcase
	end

	// Step counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upc_q  <= rwg_pkg::U_CHK_LOSS;
		end else if (in_accept) begin
			busy_q <= 1'b1;
			upc_q  <= rwg_pkg::U_CHK_LOSS;
		end else if (fire) begin
			if (ctl.last) begin
				busy_q <= 1'b0;
				upc_q  <= rwg_pkg::U_CHK_LOSS;
			end else if (jump) begin
				upc_q <= ctl.target;
			end else begin
				upc_q <= upc_q + rwg_pkg::upc_t'(1);
			end
		end
	end

	// Ack counter persists across items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (fire) begin
			case (ctl.uop)
				rwg_pkg::UOP_CMP_RESET: begin
					if (cnt_q >= w_q) begin
						cnt_q <= '0;
					end
				end
				rwg_pkg::UOP_ADD_ACK:  cnt_q <= cnt_plus_ack;
				rwg_pkg::UOP_TAKE_REM: cnt_q <= rem_q;
				default:               cnt_q <= cnt_q;
			endcase
		end
	end

	// Capture the input beat and run the datapath operations
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q    <= in_item.operation;
			win_q   <= in_item.window_bytes;
			thr_q   <= in_item.threshold_bytes;
			acked_q <= in_item.acked_segments;
		end else if (fire) begin
			case (ctl.uop)
				rwg_pkg::UOP_DIV_SEG: begin
					rem_q     <= '0;
					quo_q     <= win_q;
					dvs_q     <= {16'd0, seg};
					div_cnt_q <= 5'd31;
				end
				rwg_pkg::UOP_DIV_CNT: begin
					rem_q     <= '0;
					quo_q     <= cnt_q;
					dvs_q     <= w_q;
					div_cnt_q <= 5'd31;
				end
				rwg_pkg::UOP_DIV_STEP: begin
					if (div_diff[33]) begin
						rem_q <= div_sh[31:0];
						quo_q <= {quo_q[30:0], 1'b0};
					end else begin
						rem_q <= div_diff[31:0];
						quo_q <= {quo_q[30:0], 1'b1};
					end
					div_cnt_q <= div_cnt_q - 5'd1;
				end
				rwg_pkg::UOP_SET_W: w_q <= (quo_q == 32'd0) ? 32'd1 : quo_q;
				rwg_pkg::UOP_CMP_RESET: begin
					if (cnt_q >= w_q) begin
						win_q <= win_plus_seg;
					end
				end
				rwg_pkg::UOP_TAKE_REM: prod_q <= mul_p;
				rwg_pkg::UOP_SS_MUL:   prod_q <= mul_p;
				rwg_pkg::UOP_ADD_PROD: win_q  <= win_plus_prod;
				default: begin
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && ctl.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && ctl.last) begin
			case (ctl.uop)
				rwg_pkg::UOP_FIN_LOSS: begin
					out_q.proposed_window  <= '0;
					out_q.new_threshold    <= ({15'd0, two_seg} > half_win) ?
						{15'd0, two_seg} : half_win;
					out_q.slow_start_phase <= 1'b0;
				end
				rwg_pkg::UOP_FIN_SS: begin
					if (acked_q == 16'd0) begin
						out_q.proposed_window <= win_q;
					end else begin
						out_q.proposed_window <= (win_plus_prod < thr_q) ? win_plus_prod : thr_q;
					end
					out_q.new_threshold    <= '0;
					out_q.slow_start_phase <= 1'b1;
				end
				default: begin
					out_q.proposed_window  <= win_q;
					out_q.new_threshold    <= '0;
					out_q.slow_start_phase <= 1'b0;
				end
			endcase
		end
	end

endmodule
